>>> hdl/stli_pkg.sv
`timescale 1ns / 1ps

package stli_pkg;

    localparam int DATA_W           = 32;
    localparam int PROD_W           = 2 * DATA_W;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

>>> hdl/stli_ram.sv
`timescale 1ns / 1ps

module stli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/stli_div.sv
`timescale 1ns / 1ps

module stli_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stli_pkg::PROD_W-1:0]   dividend,
    input  logic [stli_pkg::DATA_W-1:0]   divisor,
    output logic                          done,
    output logic [stli_pkg::DATA_W-1:0]   quotient
);

    import stli_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DATA_W-1:0] rem_reg,  rem_next;
    logic [DATA_W-1:0] lo_reg,   lo_next;
    logic [DATA_W:0]   trial;

    // one quotient bit per cycle; the upper half of the dividend is below the divisor
    always_comb
    begin
        trial     = {rem_reg, lo_reg[DATA_W-1]} - {1'b0, divisor};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = dividend[PROD_W-1:DATA_W];
            lo_next  = dividend[DATA_W-1:0];
        end
        else if (run_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                lo_next  = {lo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], lo_reg[DATA_W-1]};
                lo_next  = {lo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

>>> hdl/sorted_table_linear_interp.sv
`timescale 1ns / 1ps

// Sorted key/value table with piecewise-linear lookup, signed Q16.16. A beat is taken when
// start is high and busy is low; busy then stays high until the result. Each beat yields one
// result, shown for exactly one cycle with done high; the receiver cannot stall it. Points sit in
// two single-port-read RAMs, whose reads are registered: the search visits each key with a read
// state (S_SRCH) and a compare state (S_CMP), an insert moves each entry up with a read state
// (S_SHRD) and a write state (S_SHWR), and an interpolating lookup adds a multiply step (S_MUL),
// a divider start step (S_DVST) and a bit-serial divide (S_DIV). busy falls in the cycle done
// is shown, so the next beat may be taken then.

module sorted_table_linear_interp #(
    parameter int CAPACITY = stli_pkg::DEFAULT_CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [stli_pkg::DATA_W-1:0] key,
    input  logic signed [stli_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic signed [stli_pkg::DATA_W-1:0] result_value,
    output logic [1:0]                         status
);

    import stli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_SHRD = 4'd3;
    localparam logic [3:0] S_SHWR = 4'd4;
    localparam logic [3:0] S_INS  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DVST = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;

    logic [3:0]        state_reg,  state_next;
    logic              cmd_reg,    cmd_next;
    logic [DATA_W-1:0] key_reg,    key_next;
    logic [DATA_W-1:0] val_reg,    val_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [CW-1:0]     idx_reg,    idx_next;
    logic [CW-1:0]     j_reg,      j_next;
    logic [DATA_W-1:0] pkey_reg,   pkey_next;
    logic [DATA_W-1:0] pval_reg,   pval_next;
    logic              neg_reg,    neg_next;
    logic [DATA_W-1:0] mag_reg,    mag_next;
    logic [DATA_W-1:0] dq_reg,     dq_next;
    logic [DATA_W-1:0] dk_reg,     dk_next;
    logic [PROD_W-1:0] prod_reg,   prod_next;
    logic [DATA_W-1:0] res_reg,    res_next;
    logic [1:0]        status_reg, status_next;
    logic              done_reg,   done_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] key_wdata, val_wdata;
    logic [DATA_W-1:0] key_rdata, val_rdata;
    logic [CW-1:0]     jm1;
    logic [DATA_W:0]   dv;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] quot;

    stli_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_wdata),
        .raddr (ram_raddr),
        .rdata (key_rdata)
    );

    stli_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_wdata),
        .raddr (ram_raddr),
        .rdata (val_rdata)
    );

    stli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dk_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign jm1 = j_reg - 1'b1;
    assign dv  = {val_rdata[DATA_W-1], val_rdata} - {pval_reg[DATA_W-1], pval_reg};

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        pkey_next   = pkey_reg;
        pval_next   = pval_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        dq_next     = dq_reg;
        dk_next     = dk_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_raddr   = idx_reg[AW-1:0];
        key_wdata   = key_reg;
        val_wdata   = val_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    val_next   = value;
                    idx_next   = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (cmd_reg == CMD_LOOKUP && count_reg == '0)
                begin
                    res_next    = '0;
                    status_next = ST_EMPTY;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (idx_reg == count_reg)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_next    = pval_reg;
                        status_next = ST_OK;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        res_next    = '0;
                        status_next = ST_FULL;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if ($signed(key_rdata) >= $signed(key_reg))
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        if (idx_reg == '0)
                        begin
                            res_next    = val_rdata;
                            status_next = ST_OK;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            neg_next   = dv[DATA_W];
                            mag_next   = dv[DATA_W] ? DATA_W'(-dv) : dv[DATA_W-1:0];
                            dq_next    = key_reg - pkey_reg;
                            dk_next    = key_rdata - pkey_reg;
                            state_next = S_MUL;
                        end
                    end
                    else if (key_rdata == key_reg)
                    begin
                        ram_we      = 1'b1;
                        key_wdata   = key_rdata;
                        res_next    = '0;
                        status_next = ST_OK;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        res_next    = '0;
                        status_next = ST_FULL;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        j_next     = count_reg;
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    pkey_next  = key_rdata;
                    pval_next  = val_rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SHRD:
            begin
                ram_raddr  = jm1[AW-1:0];
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg[AW-1:0];
                key_wdata  = key_rdata;
                val_wdata  = val_rdata;
                j_next     = jm1;
                state_next = (jm1 == idx_reg) ? S_INS : S_SHRD;
            end
            S_INS:
            begin
                ram_we      = 1'b1;
                count_next  = count_reg + 1'b1;
                res_next    = '0;
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(mag_reg) * PROD_W'(dq_reg);
                state_next = S_DVST;
            end
            S_DVST:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next    = neg_reg ? pval_reg - quot : pval_reg + quot;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        pkey_reg   <= pkey_next;
        pval_reg   <= pval_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        dq_reg     <= dq_next;
        dk_reg     <= dk_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign status       = status_reg;

endmodule

>>> hdl/stli_checker.sv
`timescale 1ns / 1ps

module stli_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic signed [stli_pkg::DATA_W-1:0] result_value,
    input logic [1:0]                         status
);

    import stli_pkg::*;

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside end of work");

    a_busy_falls_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> result_value == '0)
        else $error("empty-table lookup returned nonzero value");

endmodule

bind sorted_table_linear_interp stli_checker u_stli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .status       (status)
);

>>> tb/sv/stli_checker.sv
`timescale 1ns / 1ps

module stli_scoreboard
    import stli_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     command,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     done,
    input  logic signed [DATA_W-1:0] result_value,
    input  logic [1:0]               status,
    output int                       outstanding,
    output int                       fail_count
);

    typedef struct {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
    } table_answer_t;

    logic signed [DATA_W-1:0] table_keys [CAPACITY];
    logic signed [DATA_W-1:0] table_vals [CAPACITY];
    int                       point_count;
    table_answer_t            pending_answers [$];
    table_answer_t            oldest;

    function automatic int first_at_or_above(logic signed [DATA_W-1:0] k);
        int i;
        for (i = 0; i < point_count; i++)
        begin
            if (table_keys[i] >= k)
                break;
        end
        return i;
    endfunction

    function automatic logic [1:0] insert_point(logic signed [DATA_W-1:0] k,
                                                logic signed [DATA_W-1:0] v);
        int pos;
        int i;
        pos = first_at_or_above(k);
        if (pos < point_count && table_keys[pos] == k)
        begin
            table_vals[pos] = v;
            return ST_OK;
        end
        if (point_count >= CAPACITY)
            return ST_FULL;
        for (i = point_count; i > pos; i--)
        begin
            table_keys[i] = table_keys[i-1];
            table_vals[i] = table_vals[i-1];
        end
        table_keys[pos] = k;
        table_vals[pos] = v;
        point_count++;
        return ST_OK;
    endfunction

    function automatic logic signed [DATA_W-1:0] interpolate(logic signed [DATA_W-1:0] q);
        int         pos;
        longint     v0;
        longint     v1;
        longint     k0;
        longint     k1;
        longint     dv;
        longint     answer;
        bit [63:0]  mag;
        bit [63:0]  dq;
        bit [63:0]  dk;
        bit [63:0]  quot;
        pos = first_at_or_above(q);
        if (pos == 0)
            return table_vals[0];
        if (pos >= point_count)
            return table_vals[point_count-1];
        v0 = table_vals[pos-1];
        v1 = table_vals[pos];
        k0 = table_keys[pos-1];
        k1 = table_keys[pos];
        dv = v1 - v0;
        mag = (dv < 0) ? -dv : dv;
        dq = q - k0;
        dk = k1 - k0;
        quot = (mag * dq) / dk;
        answer = (dv < 0) ? v0 - longint'(quot) : v0 + longint'(quot);
        return answer[DATA_W-1:0];
    endfunction

    function automatic table_answer_t predict_beat(logic cmd,
                                                   logic signed [DATA_W-1:0] k,
                                                   logic signed [DATA_W-1:0] v);
        table_answer_t a;
        a.result_value = '0;
        a.status = ST_OK;
        if (cmd == CMD_ADD)
            a.status = insert_point(k, v);
        else if (point_count == 0)
            a.status = ST_EMPTY;
        else
            a.result_value = interpolate(k);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count = 0;
            pending_answers.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("unexpected beat: result_value %0d, status %0d",
                           result_value, status);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_answers.pop_front();
                    if (result_value !== oldest.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               oldest.result_value, result_value);
                        fail_count++;
                    end
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                pending_answers.push_back(predict_beat(command, key, value));
            outstanding <= pending_answers.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import stli_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BEATS = 1275;
    localparam int CALM_TAIL    = 150;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     command;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    int                       outstanding;
    int                       fail_count;
    int                       cycles;
    logic signed [DATA_W-1:0] point_keys [$];

    sorted_table_linear_interp uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key          (key),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .status       (status)
    );

    stli_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key          (key),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .outstanding  (outstanding),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_table_linear_interp: mismatch");
        $finish;
    end

    // hold the beat until taken, then maybe drop start for a burst
    task automatic send_beat(input logic cmd, input logic signed [DATA_W-1:0] k,
                             input logic signed [DATA_W-1:0] v, input bit allow_idle);
        start   <= 1'b1;
        command <= cmd;
        key     <= k;
        value   <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return Q_MIN;
        if (sel < 4)
            return Q_MAX;
        if (sel == 4)
            return '0;
        return $urandom;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_query();
        int                       sel;
        logic signed [DATA_W-1:0] base;
        sel = $urandom_range(0, 9);
        base = point_keys[$urandom_range(0, point_keys.size() - 1)];
        case (sel)
            4, 5:    return base;
            6:       return base + int'($urandom_range(1, 1000));
            7:       return base - int'($urandom_range(1, 1000));
            8:       return base + int'($urandom_range(1, 32'h0FFF_FFFF));
            9:
            begin
                case ($urandom_range(0, 3))
                    0:       return Q_MIN;
                    1:       return Q_MAX;
                    2:       return Q_MIN + 1;
                    default: return Q_MAX - 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int                       n;
        int                       sel;
        int                       slot;
        bit                       allow;
        logic signed [DATA_W-1:0] k;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        command <= CMD_ADD;
        key     <= '0;
        value   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        send_beat(CMD_LOOKUP, '0, '0, 1'b1);
        send_beat(CMD_LOOKUP, Q_MIN, Q_MAX, 1'b1);

        // single point, then the two key extremes
        send_beat(CMD_ADD, Q_MIN, Q_MAX, 1'b1);
        point_keys.push_back(Q_MIN);
        send_beat(CMD_LOOKUP, 32'sd5, '0, 1'b1);
        send_beat(CMD_ADD, Q_MAX, Q_MIN, 1'b1);
        point_keys.push_back(Q_MAX);
        send_beat(CMD_LOOKUP, Q_MIN, '0, 1'b1);
        send_beat(CMD_LOOKUP, Q_MAX, '0, 1'b1);
        send_beat(CMD_LOOKUP, '0, '0, 1'b1);
        send_beat(CMD_ADD, Q_MAX, '0, 1'b1);
        send_beat(CMD_LOOKUP, -32'sd1, '0, 1'b1);

        // fill in scrambled order so inserts land at every position
        for (n = 0; n < 14; n++)
        begin
            slot = (n * 5) % 14 + 1;
            k = (slot - 8) * (1 << 28) + int'($urandom_range(0, 32'h0800_0000));
            point_keys.push_back(k);
            send_beat(CMD_ADD, k, $urandom, 1'b1);
        end

        // full table: new key dropped, existing key replaced
        send_beat(CMD_ADD, Q_MAX - 1, 32'sd7, 1'b1);
        send_beat(CMD_ADD, point_keys[4], Q_MIN, 1'b1);
        send_beat(CMD_LOOKUP, point_keys[4], '0, 1'b1);
        send_beat(CMD_LOOKUP, point_keys[4] + 1, '0, 1'b1);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            allow = (n < RANDOM_BEATS - CALM_TAIL);
            if (n == RANDOM_BEATS / 2)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 55)
                send_beat(CMD_LOOKUP, pick_query(), $urandom, allow);
            else if (sel < 80)
                send_beat(CMD_ADD, point_keys[$urandom_range(0, point_keys.size() - 1)],
                          pick_value(), allow);
            else if (sel < 92)
                send_beat(CMD_ADD, $urandom, pick_value(), allow);
            else
                send_beat(CMD_LOOKUP, $urandom, pick_value(), allow);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("sorted_table_linear_interp: match");
        else
            $display("sorted_table_linear_interp: mismatch");
        $finish;
    end

endmodule
